FILE: src/bvhts_pkg.sv
// Shared types, codes and constants of the BVH traversal stack scheduler.
// No dependencies; imported by every module of the block.
package bvhts_pkg;

  localparam int FUNC_W      = 3;
  localparam int SLOT_W      = 6;
  localparam int RAY_SLOTS   = 64;
  localparam int DIST_W      = 32;
  localparam int PRIM_W      = 32;
  localparam int ADDR_W      = 48;
  localparam int LEN_W       = 16;
  localparam int INDEX_W     = 16;
  localparam int CNT_W       = 4;
  localparam int TSTRIDE_W   = 24;
  localparam int RSTRIDE_W   = 12;
  localparam int CFG_IDX_W   = 2;
  localparam int STACK_DEPTH_DEF = 32;
  localparam int TRI_OFFSET_SHIFT = 2;

  localparam logic [TSTRIDE_W-1:0] TSTRIDE_RST = TSTRIDE_W'(65536);
  localparam logic [RSTRIDE_W-1:0] NSTRIDE_RST = RSTRIDE_W'(64);
  localparam logic [RSTRIDE_W-1:0] RSTRIDE_RST = RSTRIDE_W'(48);
  localparam logic [PRIM_W-1:0]    NO_HIT      = '1;

  typedef enum logic [FUNC_W-1:0] {
    FN_START      = 3'd0,
    FN_BEGIN_NODE = 3'd1,
    FN_OFFER      = 3'd2,
    FN_SCHEDULE   = 3'd3,
    FN_HIT_UPDATE = 3'd4
  } func_t;

  typedef enum logic [2:0] {
    OC_NODE     = 3'd0,
    OC_TRI      = 3'd1,
    OC_CULL     = 3'd2,
    OC_HIT      = 3'd3,
    OC_ACCEPT   = 3'd4,
    OC_REJECT   = 3'd5,
    OC_OVERFLOW = 3'd6,
    OC_NOSLOT   = 3'd7
  } outcome_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE    = 2'd0,
    CFG_TSTRIDE = 2'd1,
    CFG_NSTRIDE = 2'd2,
    CFG_RSTRIDE = 2'd3
  } cfg_idx_t;

  // Stack entry payload, most significant field first.
  typedef struct packed {
    logic [INDEX_W-1:0] treelet;
    logic [CNT_W-1:0]   tris;
    logic               other;
    logic               interior;
    logic [INDEX_W-1:0] index;
  } payload_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    payload_t          pay;
  } entry_t;

  // Controller to datapath.
  typedef struct packed {
    logic     take;
    logic     load_state;
    logic     stk_rd_top;
    logic     stk_wr_new;
    logic     stk_wr_shift;
    logic     j_from_h;
    logic     j_dec;
    logic     h_inc;
    logic     h_dec;
    logic     fl_from_h;
    logic     hit_take;
    logic     pop_latch;
    logic     mul;
    logic     sum;
    logic     out_load;
    logic     use_clr;
    outcome_t outcome;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic              in_fire;
    logic [FUNC_W-1:0] func;
    logic              live;
    logic              no_free;
    logic              dist_ge_cd;
    logic              h_zero;
    logic              h_full;
    logic              j_gt_fl;
    logic              rd_gt_dist;
    logic              top_ge_cd;
    logic              top_interior;
    logic              out_can_load;
  } status_t;

endpackage

FILE: src/bvh_traversal_stack_scheduler_unit.sv
// Top level of the BVH traversal stack scheduler.
// Depends on bvhts_pkg, bvhts_ctrl and bvhts_datapath.
//
// Usage:
//   Commands arrive on the in_ valid/ready channel, one transaction per
//   command, and each command returns exactly one result transaction on
//   the out_ channel. Configuration registers are written through cfg_we,
//   cfg_index and cfg_wdata while the block is idle.
//   Commands are handled one at a time by a controller walking through the
//   per-slot state memory and the stack memory. Every command loads the
//   slot state, decides its outcome and then loads the result register.
//   Begin node, hit update, start and rejected commands need no further
//   step. Schedule returns a hit at once on an empty stack, else reads the
//   top entry and culls it, or, for a node or triangle fetch, multiplies
//   and then adds the address terms in two registered steps. Offer child
//   ends the sorted insertion at the floor or below a farther entry, and
//   every entry shifted up reads the stack memory and writes it back.
//   Results are held in an output register: if the receiver stalls, the
//   next command may still be accepted and worked on, and it waits at its
//   last step until the register frees up.
//   Synchronous reset clears all slots to idle, restores the default
//   strides and empties the result register; no memory clearing pass runs.
module bvh_traversal_stack_scheduler_unit #(
  parameter int STACK_DEPTH = bvhts_pkg::STACK_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [bvhts_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bvhts_pkg::ADDR_W-1:0]       cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [bvhts_pkg::FUNC_W-1:0]       in_func,
  input  logic [bvhts_pkg::SLOT_W-1:0]       in_ray_slot,
  input  logic [bvhts_pkg::DIST_W-1:0]       in_distance,
  input  logic [bvhts_pkg::DIST_W-1:0]       in_far_limit,
  input  logic [bvhts_pkg::PRIM_W-1:0]       in_primitive_id,
  input  logic                               in_child_is_interior,
  input  logic                               in_child_in_other_treelet,
  input  logic [bvhts_pkg::INDEX_W-1:0]      in_child_index,
  input  logic [bvhts_pkg::CNT_W-1:0]        in_leaf_triangles,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [2:0]                         out_outcome,
  output logic [bvhts_pkg::SLOT_W-1:0]       out_ray_slot_out,
  output logic [bvhts_pkg::ADDR_W-1:0]       out_fetch_address,
  output logic [bvhts_pkg::LEN_W-1:0]        out_fetch_length,
  output logic [bvhts_pkg::CNT_W-1:0]        out_triangle_count,
  output logic [bvhts_pkg::DIST_W-1:0]       out_hit_distance,
  output logic [bvhts_pkg::PRIM_W-1:0]       out_hit_primitive
);
  import bvhts_pkg::*;

  // Command and status groups between the controller and the datapath.
  cmd_t    cmd;
  status_t sts;

  // The controller decides the outcome of each command from datapath
  // status and steps through insertion, pop and address phases.
  bvhts_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  // The datapath owns all storage, the address arithmetic and the result
  // register.
  bvhts_datapath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_datapath (
    .clk                       (clk),
    .rst_n                     (rst_n),
    .cmd                       (cmd),
    .sts                       (sts),
    .cfg_we                    (cfg_we),
    .cfg_index                 (cfg_index),
    .cfg_wdata                 (cfg_wdata),
    .in_valid                  (in_valid),
    .in_ready                  (in_ready),
    .in_func                   (in_func),
    .in_ray_slot               (in_ray_slot),
    .in_distance               (in_distance),
    .in_far_limit              (in_far_limit),
    .in_primitive_id           (in_primitive_id),
    .in_child_is_interior      (in_child_is_interior),
    .in_child_in_other_treelet (in_child_in_other_treelet),
    .in_child_index            (in_child_index),
    .in_leaf_triangles         (in_leaf_triangles),
    .out_valid                 (out_valid),
    .out_ready                 (out_ready),
    .out_outcome               (out_outcome),
    .out_ray_slot_out          (out_ray_slot_out),
    .out_fetch_address         (out_fetch_address),
    .out_fetch_length          (out_fetch_length),
    .out_triangle_count        (out_triangle_count),
    .out_hit_distance          (out_hit_distance),
    .out_hit_primitive         (out_hit_primitive)
  );

endmodule

FILE: src/bvhts_datapath.sv
// Datapath: configuration registers, per-slot state memory, stack memory,
// address arithmetic and the result register. Depends on bvhts_pkg.
module bvhts_datapath #(
  parameter int STACK_DEPTH = bvhts_pkg::STACK_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  bvhts_pkg::cmd_t                     cmd,
  output bvhts_pkg::status_t                  sts,
  input  logic                                cfg_we,
  input  logic [bvhts_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bvhts_pkg::ADDR_W-1:0]        cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [bvhts_pkg::FUNC_W-1:0]        in_func,
  input  logic [bvhts_pkg::SLOT_W-1:0]        in_ray_slot,
  input  logic [bvhts_pkg::DIST_W-1:0]        in_distance,
  input  logic [bvhts_pkg::DIST_W-1:0]        in_far_limit,
  input  logic [bvhts_pkg::PRIM_W-1:0]        in_primitive_id,
  input  logic                                in_child_is_interior,
  input  logic                                in_child_in_other_treelet,
  input  logic [bvhts_pkg::INDEX_W-1:0]       in_child_index,
  input  logic [bvhts_pkg::CNT_W-1:0]         in_leaf_triangles,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [2:0]                          out_outcome,
  output logic [bvhts_pkg::SLOT_W-1:0]        out_ray_slot_out,
  output logic [bvhts_pkg::ADDR_W-1:0]        out_fetch_address,
  output logic [bvhts_pkg::LEN_W-1:0]         out_fetch_length,
  output logic [bvhts_pkg::CNT_W-1:0]         out_triangle_count,
  output logic [bvhts_pkg::DIST_W-1:0]        out_hit_distance,
  output logic [bvhts_pkg::PRIM_W-1:0]        out_hit_primitive
);
  import bvhts_pkg::*;

  localparam int HW = $clog2(STACK_DEPTH + 1);
  localparam int IW = $clog2(STACK_DEPTH);
  localparam int SDEPTH = RAY_SLOTS << IW;

  typedef struct packed {
    logic [HW-1:0]      height;
    logic [HW-1:0]      floor;
    logic [DIST_W-1:0]  cd;
    logic [PRIM_W-1:0]  cp;
    logic [INDEX_W-1:0] treelet;
  } slot_state_t;

  logic [ADDR_W-1:0]    base_r;
  logic [TSTRIDE_W-1:0] tstride_r;
  logic [RSTRIDE_W-1:0] nstride_r;
  logic [RSTRIDE_W-1:0] rstride_r;

  logic [FUNC_W-1:0]  func_r;
  logic [DIST_W-1:0]  dist_r;
  logic [DIST_W-1:0]  far_r;
  logic [PRIM_W-1:0]  prim_r;
  logic               int_r;
  logic               oth_r;
  logic [INDEX_W-1:0] cidx_r;
  logic [CNT_W-1:0]   ltris_r;
  logic [SLOT_W-1:0]  sidx_r;
  logic               nofree_r;

  logic [RAY_SLOTS-1:0] use_r;
  logic [HW-1:0]        h_r;
  logic [HW-1:0]        fl_r;
  logic [HW-1:0]        j_r;
  logic [DIST_W-1:0]    cd_r;
  logic [PRIM_W-1:0]    cp_r;
  logic [INDEX_W-1:0]   at_r;

  slot_state_t st_mem [RAY_SLOTS];
  slot_state_t st_rdata_r;
  entry_t      stk_mem [SDEPTH];
  entry_t      stk_rdata_r;

  logic [INDEX_W-1:0]       sel_tr_r;
  logic [INDEX_W-1:0]       sel_idx_r;
  logic                     node_r;
  logic [CNT_W-1:0]         cnt_r;
  logic [INDEX_W+TSTRIDE_W-1:0] p1_r;
  logic [INDEX_W+RSTRIDE_W-1:0] p2_r;
  logic [LEN_W-1:0]         len_r;
  logic [ADDR_W-1:0]        addr_r;

  logic               out_valid_r;
  logic [2:0]         oc_r;
  logic [SLOT_W-1:0]  oslot_r;
  logic [ADDR_W-1:0]  oaddr_r;
  logic [LEN_W-1:0]   olen_r;
  logic [CNT_W-1:0]   ocnt_r;
  logic [DIST_W-1:0]  ohd_r;
  logic [PRIM_W-1:0]  ohp_r;

  logic              in_fire;
  logic              free_found;
  logic [SLOT_W-1:0] free_idx;
  logic [SLOT_W-1:0] st_raddr;
  logic [HW-1:0]     rd_pos;
  logic [IW-1:0]     rd_idx;
  logic              is_start_ok;
  entry_t            new_entry;
  payload_t          pop_pay;
  logic              fetch_oc;

  assign in_ready = cmd.take;
  assign in_fire  = in_valid && cmd.take;

  // Lowest free ray slot.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int k = RAY_SLOTS - 1; k >= 0; k--) begin
      if (!use_r[k]) begin
        free_found = 1'b1;
        free_idx   = SLOT_W'(k);
      end
    end
  end

  assign st_raddr = in_fire ? ((in_func == FN_START) ? free_idx : in_ray_slot) : sidx_r;
  assign is_start_ok = (func_r == FN_START) && !nofree_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r    <= '0;
      tstride_r <= TSTRIDE_RST;
      nstride_r <= NSTRIDE_RST;
      rstride_r <= RSTRIDE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BASE:    base_r    <= cfg_wdata;
        CFG_TSTRIDE: tstride_r <= cfg_wdata[TSTRIDE_W-1:0];
        CFG_NSTRIDE: nstride_r <= cfg_wdata[RSTRIDE_W-1:0];
        CFG_RSTRIDE: rstride_r <= cfg_wdata[RSTRIDE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      func_r   <= in_func;
      dist_r   <= in_distance;
      far_r    <= in_far_limit;
      prim_r   <= in_primitive_id;
      int_r    <= in_child_is_interior;
      oth_r    <= in_child_in_other_treelet;
      cidx_r   <= in_child_index;
      ltris_r  <= in_leaf_triangles;
      nofree_r <= !free_found;
      sidx_r   <= (in_func == FN_START) ? (free_found ? free_idx : '0) : in_ray_slot;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      use_r <= '0;
    end else if (cmd.load_state && is_start_ok) begin
      use_r[sidx_r] <= 1'b1;
    end else if (cmd.use_clr) begin
      use_r[sidx_r] <= 1'b0;
    end
  end

  // Per-slot state memory; written back when the result is loaded.
  always_ff @(posedge clk) begin
    st_rdata_r <= st_mem[st_raddr];
    if (cmd.out_load) begin
      st_mem[sidx_r] <= '{height: h_r, floor: fl_r, cd: cd_r, cp: cp_r, treelet: at_r};
    end
  end

  // Working copy of the addressed slot's state.
  always_ff @(posedge clk) begin
    if (cmd.load_state) begin
      j_r <= '0;
      if (is_start_ok) begin
        h_r  <= HW'(1);
        fl_r <= '0;
        cd_r <= far_r;
        cp_r <= NO_HIT;
        at_r <= '0;
      end else begin
        h_r  <= st_rdata_r.height;
        fl_r <= st_rdata_r.floor;
        cd_r <= st_rdata_r.cd;
        cp_r <= st_rdata_r.cp;
        at_r <= st_rdata_r.treelet;
      end
    end else begin
      if (cmd.j_from_h) j_r <= h_r;
      else if (cmd.j_dec) j_r <= j_r - HW'(1);
      if (cmd.h_inc) h_r <= h_r + HW'(1);
      else if (cmd.h_dec) h_r <= h_r - HW'(1);
      if (cmd.fl_from_h) fl_r <= h_r;
      if (cmd.hit_take) begin
        cd_r <= dist_r;
        cp_r <= prim_r;
      end
      if (cmd.pop_latch && pop_pay.interior) begin
        at_r <= pop_pay.other ? pop_pay.index : pop_pay.treelet;
      end
    end
  end

  // Stack memory: one read and one write per cycle, read data registered.
  assign rd_pos = cmd.stk_rd_top ? (h_r - HW'(1)) : (j_r - HW'(1));
  assign rd_idx = rd_pos[IW-1:0];

  always_comb begin
    new_entry.distance = dist_r;
    if (func_r == FN_START) begin
      new_entry.pay = '{treelet: '0, tris: '0, other: 1'b0, interior: 1'b1, index: '0};
    end else begin
      new_entry.pay = '{treelet: at_r, tris: ltris_r, other: oth_r,
                        interior: int_r, index: cidx_r};
    end
  end

  always_ff @(posedge clk) begin
    stk_rdata_r <= stk_mem[{sidx_r, rd_idx}];
    if (cmd.stk_wr_new) begin
      stk_mem[{sidx_r, j_r[IW-1:0]}] <= new_entry;
    end else if (cmd.stk_wr_shift) begin
      stk_mem[{sidx_r, j_r[IW-1:0]}] <= stk_rdata_r;
    end
  end

  assign pop_pay = stk_rdata_r.pay;

  // Fetch address: select operands, multiply, then add.
  always_ff @(posedge clk) begin
    if (cmd.pop_latch) begin
      node_r    <= pop_pay.interior;
      cnt_r     <= pop_pay.tris;
      sel_tr_r  <= pop_pay.interior ? (pop_pay.other ? pop_pay.index : pop_pay.treelet)
                                    : at_r;
      sel_idx_r <= (pop_pay.interior && pop_pay.other) ? '0 : pop_pay.index;
    end
    if (cmd.mul) begin
      p1_r <= sel_tr_r * tstride_r;
      if (node_r) begin
        p2_r  <= sel_idx_r * nstride_r;
        len_r <= LEN_W'(nstride_r);
      end else begin
        p2_r  <= (INDEX_W+RSTRIDE_W)'({sel_idx_r, TRI_OFFSET_SHIFT'(0)});
        len_r <= LEN_W'(rstride_r) * LEN_W'(cnt_r);
      end
    end
    if (cmd.sum) begin
      addr_r <= base_r + ADDR_W'(p1_r) + ADDR_W'(p2_r);
    end
  end

  // Result register.
  assign fetch_oc = (cmd.outcome == OC_NODE) || (cmd.outcome == OC_TRI);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      oc_r    <= cmd.outcome;
      oslot_r <= sidx_r;
      oaddr_r <= fetch_oc ? addr_r : '0;
      olen_r  <= fetch_oc ? len_r : '0;
      ocnt_r  <= (cmd.outcome == OC_TRI) ? cnt_r : '0;
      ohd_r   <= use_r[sidx_r] ? cd_r : '0;
      ohp_r   <= use_r[sidx_r] ? cp_r : '0;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_outcome        = oc_r;
  assign out_ray_slot_out   = oslot_r;
  assign out_fetch_address  = oaddr_r;
  assign out_fetch_length   = olen_r;
  assign out_triangle_count = ocnt_r;
  assign out_hit_distance   = ohd_r;
  assign out_hit_primitive  = ohp_r;

  assign sts.in_fire      = in_fire;
  assign sts.func         = func_r;
  assign sts.live         = use_r[sidx_r];
  assign sts.no_free      = nofree_r;
  assign sts.dist_ge_cd   = dist_r >= cd_r;
  assign sts.h_zero       = h_r == '0;
  assign sts.h_full       = h_r >= HW'(STACK_DEPTH);
  assign sts.j_gt_fl      = j_r > fl_r;
  assign sts.rd_gt_dist   = stk_rdata_r.distance > dist_r;
  assign sts.top_ge_cd    = stk_rdata_r.distance >= cd_r;
  assign sts.top_interior = pop_pay.interior;
  assign sts.out_can_load = !out_valid_r || out_ready;

endmodule

FILE: src/bvhts_ctrl.sv
// Controller state machine that sequences one command through the datapath.
// Depends on bvhts_pkg.
module bvhts_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  bvhts_pkg::status_t  sts,
  output bvhts_pkg::cmd_t     cmd
);
  import bvhts_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_DEC, S_INS, S_INSC, S_POP, S_MUL, S_SUM, S_DONE
  } state_t;

  state_t   state_r, state_nxt;
  outcome_t oc_r, oc_nxt;

  always_comb begin
    cmd       = '0;
    cmd.outcome = oc_r;
    state_nxt = state_r;
    oc_nxt    = oc_r;
    case (state_r)
      S_IDLE: begin
        cmd.take = 1'b1;
        if (sts.in_fire) state_nxt = S_LOAD;
      end
      S_LOAD: begin
        cmd.load_state = 1'b1;
        state_nxt = S_DEC;
      end
      S_DEC: begin
        state_nxt = S_DONE;
        if (sts.func == FN_START) begin
          if (sts.no_free) begin
            oc_nxt = OC_NOSLOT;
          end else begin
            cmd.stk_wr_new = 1'b1;
            oc_nxt = OC_ACCEPT;
          end
        end else if (!sts.live) begin
          oc_nxt = OC_REJECT;
        end else begin
          case (sts.func)
            FN_BEGIN_NODE: begin
              cmd.fl_from_h = 1'b1;
              oc_nxt = OC_ACCEPT;
            end
            FN_OFFER: begin
              if (sts.dist_ge_cd) begin
                oc_nxt = OC_REJECT;
              end else if (sts.h_full) begin
                oc_nxt = OC_OVERFLOW;
              end else begin
                cmd.j_from_h = 1'b1;
                cmd.h_inc    = 1'b1;
                oc_nxt       = OC_ACCEPT;
                state_nxt    = S_INS;
              end
            end
            FN_SCHEDULE: begin
              if (sts.h_zero) begin
                oc_nxt = OC_HIT;
              end else begin
                cmd.stk_rd_top = 1'b1;
                cmd.h_dec      = 1'b1;
                state_nxt      = S_POP;
              end
            end
            FN_HIT_UPDATE: begin
              if (sts.dist_ge_cd) begin
                oc_nxt = OC_REJECT;
              end else begin
                cmd.hit_take = 1'b1;
                oc_nxt = OC_ACCEPT;
              end
            end
            default: oc_nxt = OC_REJECT;
          endcase
        end
      end
      S_INS: begin
        if (sts.j_gt_fl) begin
          state_nxt = S_INSC;
        end else begin
          cmd.stk_wr_new = 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_INSC: begin
        if (sts.rd_gt_dist) begin
          cmd.stk_wr_new = 1'b1;
          state_nxt = S_DONE;
        end else begin
          cmd.stk_wr_shift = 1'b1;
          cmd.j_dec = 1'b1;
          state_nxt = S_INS;
        end
      end
      S_POP: begin
        if (sts.top_ge_cd) begin
          oc_nxt = OC_CULL;
          state_nxt = S_DONE;
        end else begin
          cmd.pop_latch = 1'b1;
          // The popped entry's node flag picks a node or a triangle fetch.
          oc_nxt = sts.top_interior ? OC_NODE : OC_TRI;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul = 1'b1;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        cmd.sum = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (sts.out_can_load) begin
          cmd.out_load = 1'b1;
          cmd.use_clr  = (oc_r == OC_HIT);
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      oc_r    <= OC_ACCEPT;
    end else begin
      state_r <= state_nxt;
      oc_r    <= oc_nxt;
    end
  end

endmodule

FILE: src/bvhts_checker.sv
// Port-level checks of the BVH traversal stack scheduler, bound to its top.
// Depends on bvhts_pkg and bvh_traversal_stack_scheduler_unit.
module bvhts_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [2:0]                    out_outcome,
  input logic [bvhts_pkg::SLOT_W-1:0]  out_ray_slot_out,
  input logic [bvhts_pkg::ADDR_W-1:0]  out_fetch_address,
  input logic [bvhts_pkg::LEN_W-1:0]   out_fetch_length,
  input logic [bvhts_pkg::CNT_W-1:0]   out_triangle_count
);
  import bvhts_pkg::*;

  // A stalled result keeps its outcome.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_outcome))
    else $error("stalled result changed");

  // Only fetches carry an address or a length.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_outcome != OC_NODE && out_outcome != OC_TRI |->
      out_fetch_address == '0 && out_fetch_length == '0)
    else $error("fetch fields set on a non-fetch result");

  // Only a triangle fetch carries a triangle count.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_outcome != OC_TRI |-> out_triangle_count == '0)
    else $error("triangle count set on a non-triangle result");

  // A failed start reports slot zero.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_outcome == OC_NOSLOT |-> out_ray_slot_out == '0)
    else $error("no-slot result names a slot");

  // Reset empties the result register.
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind bvh_traversal_stack_scheduler_unit bvhts_checker u_bvhts_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_outcome        (out_outcome),
  .out_ray_slot_out   (out_ray_slot_out),
  .out_fetch_address  (out_fetch_address),
  .out_fetch_length   (out_fetch_length),
  .out_triangle_count (out_triangle_count)
);

FILE: bench/bvh_traversal_stack_scheduler_unit_tb.sv
// Testbench for the BVH traversal stack scheduler: drives ray commands, predicts each
// result with a behavioral stack model and compares every result field.
// Depends on bvhts_pkg and bvh_traversal_stack_scheduler_unit.
module bvh_traversal_stack_scheduler_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bvhts_pkg::*;

  localparam int DEPTH = STACK_DEPTH_DEF;
  localparam int IDLE_LIMIT = 20000;

  // One command and one result, as the ports carry them.
  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [SLOT_W-1:0]  slot;
    logic [DIST_W-1:0]  distance;
    logic [DIST_W-1:0]  far;
    logic [PRIM_W-1:0]  prim;
    logic               interior;
    logic               other;
    logic [INDEX_W-1:0] index;
    logic [CNT_W-1:0]   tris;
  } ray_cmd_t;

  typedef struct packed {
    outcome_t           outcome;
    logic [SLOT_W-1:0]  slot;
    logic [ADDR_W-1:0]  addr;
    logic [LEN_W-1:0]   len;
    logic [CNT_W-1:0]   cnt;
    logic [DIST_W-1:0]  hit_dist;
    logic [PRIM_W-1:0]  hit_prim;
  } ray_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [ADDR_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [FUNC_W-1:0] in_func = '0;
  logic [SLOT_W-1:0] in_ray_slot = '0;
  logic [DIST_W-1:0] in_distance = '0;
  logic [DIST_W-1:0] in_far_limit = '0;
  logic [PRIM_W-1:0] in_primitive_id = '0;
  logic in_child_is_interior = 1'b0;
  logic in_child_in_other_treelet = 1'b0;
  logic [INDEX_W-1:0] in_child_index = '0;
  logic [CNT_W-1:0] in_leaf_triangles = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [2:0] out_outcome;
  logic [SLOT_W-1:0] out_ray_slot_out;
  logic [ADDR_W-1:0] out_fetch_address;
  logic [LEN_W-1:0] out_fetch_length;
  logic [CNT_W-1:0] out_triangle_count;
  logic [DIST_W-1:0] out_hit_distance;
  logic [PRIM_W-1:0] out_hit_primitive;

  always #2 clk = ~clk;

  bvh_traversal_stack_scheduler_unit dut (.*);

  // Shadow copy of the block's per-ray state and registers.
  logic [ADDR_W-1:0]    base_addr;
  logic [TSTRIDE_W-1:0] treelet_stride;
  logic [RSTRIDE_W-1:0] node_stride;
  logic [RSTRIDE_W-1:0] tri_stride;
  logic [DIST_W-1:0]    stk_dist [RAY_SLOTS][DEPTH];
  payload_t             stk_pay [RAY_SLOTS][DEPTH];
  int                   height [RAY_SLOTS];
  int                   floor_lvl [RAY_SLOTS];
  logic [DIST_W-1:0]    closest_dist [RAY_SLOTS];
  logic [PRIM_W-1:0]    closest_prim [RAY_SLOTS];
  logic [INDEX_W-1:0]   cur_treelet [RAY_SLOTS];
  bit                   busy [RAY_SLOTS];

  ray_result_t pending_results[$];
  int errors = 0;
  int idle_cycles = 0;
  int burst_left = 0;

  function automatic ray_result_t make_result(outcome_t oc, int s, logic [ADDR_W-1:0] a,
                                              logic [LEN_W-1:0] l, logic [CNT_W-1:0] c);
    ray_result_t r;
    r.outcome = oc;
    r.slot = SLOT_W'(s);
    r.addr = a;
    r.len = l;
    r.cnt = c;
    r.hit_dist = busy[s] ? closest_dist[s] : '0;
    r.hit_prim = busy[s] ? closest_prim[s] : '0;
    return r;
  endfunction

  // Applies one command to the shadow state and returns the result it causes.
  function automatic ray_result_t traverse_step(ray_cmd_t c);
    int s;
    int j;
    int free_slot;
    logic [DIST_W-1:0] t;
    payload_t p;
    logic [ADDR_W-1:0] a;
    logic [INDEX_W-1:0] tr;
    logic [INDEX_W-1:0] idx;
    ray_result_t r;
    s = int'(c.slot);
    if (c.func == FN_START) begin
      free_slot = -1;
      for (int i = RAY_SLOTS - 1; i >= 0; i--)
        if (!busy[i]) free_slot = i;
      if (free_slot < 0) return make_result(OC_NOSLOT, 0, '0, '0, '0);
      busy[free_slot] = 1'b1;
      closest_dist[free_slot] = c.far;
      closest_prim[free_slot] = NO_HIT;
      cur_treelet[free_slot] = '0;
      floor_lvl[free_slot] = 0;
      height[free_slot] = 1;
      stk_dist[free_slot][0] = c.distance;
      stk_pay[free_slot][0] = '{treelet: '0, tris: '0, other: 1'b0, interior: 1'b1,
                                index: '0};
      return make_result(OC_ACCEPT, free_slot, '0, '0, '0);
    end
    if (c.func > FN_HIT_UPDATE || !busy[s]) return make_result(OC_REJECT, s, '0, '0, '0);
    case (c.func)
      FN_BEGIN_NODE: begin
        floor_lvl[s] = height[s];
        r = make_result(OC_ACCEPT, s, '0, '0, '0);
      end
      FN_OFFER: begin
        if (c.distance >= closest_dist[s]) return make_result(OC_REJECT, s, '0, '0, '0);
        if (height[s] >= DEPTH) return make_result(OC_OVERFLOW, s, '0, '0, '0);
        j = height[s];
        height[s] = j + 1;
        // Nearer-or-equal entries above the floor move up so the nearest ends on top.
        while (j > floor_lvl[s] && stk_dist[s][j-1] <= c.distance) begin
          stk_dist[s][j] = stk_dist[s][j-1];
          stk_pay[s][j] = stk_pay[s][j-1];
          j--;
        end
        stk_dist[s][j] = c.distance;
        stk_pay[s][j] = '{treelet: cur_treelet[s], tris: c.tris, other: c.other,
                          interior: c.interior, index: c.index};
        r = make_result(OC_ACCEPT, s, '0, '0, '0);
      end
      FN_SCHEDULE: begin
        if (height[s] == 0) begin
          r = make_result(OC_HIT, s, '0, '0, '0);
          busy[s] = 1'b0;
          return r;
        end
        height[s]--;
        t = stk_dist[s][height[s]];
        p = stk_pay[s][height[s]];
        if (t >= closest_dist[s]) return make_result(OC_CULL, s, '0, '0, '0);
        idx = p.index;
        if (p.interior) begin
          tr = p.treelet;
          if (p.other) begin
            tr = idx;
            idx = '0;
          end
          cur_treelet[s] = tr;
          a = base_addr + ADDR_W'(tr) * ADDR_W'(treelet_stride)
              + ADDR_W'(idx) * ADDR_W'(node_stride);
          r = make_result(OC_NODE, s, a, LEN_W'(node_stride), '0);
        end else begin
          a = base_addr + ADDR_W'(cur_treelet[s]) * ADDR_W'(treelet_stride)
              + (ADDR_W'(idx) << TRI_OFFSET_SHIFT);
          r = make_result(OC_TRI, s, a, LEN_W'(tri_stride) * LEN_W'(p.tris), p.tris);
        end
      end
      default: begin
        if (c.distance < closest_dist[s]) begin
          closest_dist[s] = c.distance;
          closest_prim[s] = c.prim;
          r = make_result(OC_ACCEPT, s, '0, '0, '0);
        end else begin
          r = make_result(OC_REJECT, s, '0, '0, '0);
        end
      end
    endcase
    return r;
  endfunction

  task automatic reset_model();
    base_addr = '0;
    treelet_stride = TSTRIDE_RST;
    node_stride = NSTRIDE_RST;
    tri_stride = RSTRIDE_RST;
    for (int i = 0; i < RAY_SLOTS; i++) begin
      height[i] = 0;
      floor_lvl[i] = 0;
      closest_dist[i] = '0;
      closest_prim[i] = NO_HIT;
      cur_treelet[i] = '0;
      busy[i] = 1'b0;
    end
  endtask

  // Sends one command in a bursty pattern and records its predicted result.
  // Valid stays high between commands of a burst and drops for each gap.
  task automatic send_cmd(ray_cmd_t c);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 2) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_func <= c.func;
    in_ray_slot <= c.slot;
    in_distance <= c.distance;
    in_far_limit <= c.far;
    in_primitive_id <= c.prim;
    in_child_is_interior <= c.interior;
    in_child_in_other_treelet <= c.other;
    in_child_index <= c.index;
    in_leaf_triangles <= c.tris;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(traverse_step(c));
    @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [ADDR_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_BASE:    base_addr = val;
      CFG_TSTRIDE: treelet_stride = val[TSTRIDE_W-1:0];
      CFG_NSTRIDE: node_stride = val[RSTRIDE_W-1:0];
      default:     tri_stride = val[RSTRIDE_W-1:0];
    endcase
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  function automatic ray_cmd_t rand_cmd(logic [FUNC_W-1:0] f, int s);
    ray_cmd_t c;
    c.func = f;
    c.slot = SLOT_W'(s);
    c.distance = $urandom();
    c.far = $urandom();
    c.prim = $urandom();
    c.interior = 1'($urandom_range(0, 1));
    c.other = 1'($urandom_range(0, 1));
    c.index = INDEX_W'($urandom());
    c.tris = CNT_W'($urandom());
    return c;
  endfunction

  // First slot live in the shadow state at or after a random start, or that random slot if none is.
  function automatic int live_slot();
    int pick;
    pick = $urandom_range(0, RAY_SLOTS - 1);
    for (int k = 0; k < RAY_SLOTS; k++)
      if (busy[(pick + k) % RAY_SLOTS]) return (pick + k) % RAY_SLOTS;
    return pick;
  endfunction

  // Extremes of the fields, every command, overflow and bad codes.
  task automatic test_directed();
    ray_cmd_t c;
    c = rand_cmd(FN_START, 0);
    c.distance = '0;
    c.far = '1;
    send_cmd(c);
    c = rand_cmd(FN_BEGIN_NODE, 0);
    send_cmd(c);
    c = rand_cmd(FN_OFFER, 0);
    c.distance = 32'hFFFF_FFFE;
    c.interior = 1'b1;
    c.other = 1'b1;
    c.index = '1;
    send_cmd(c);
    c = rand_cmd(FN_OFFER, 0);
    c.distance = 32'h0;
    c.interior = 1'b0;
    c.index = '1;
    c.tris = '1;
    send_cmd(c);
    c = rand_cmd(FN_OFFER, 0);
    c.distance = '1;
    send_cmd(c);
    for (int i = 0; i < 4; i++) send_cmd(rand_cmd(FN_SCHEDULE, 0));
    send_cmd(rand_cmd(FN_HIT_UPDATE, 0));
    send_cmd(rand_cmd(FN_HIT_UPDATE, 5));
    send_cmd(rand_cmd(FUNC_W'(5), 0));
    send_cmd(rand_cmd(FUNC_W'(7), 0));
    // Fill one stack past its depth so the last offers overflow.
    c = rand_cmd(FN_START, 0);
    c.far = '1;
    send_cmd(c);
    for (int i = 0; i < DEPTH + 1; i++) begin
      c = rand_cmd(FN_OFFER, 0);
      c.distance = $urandom_range(0, 1000);
      send_cmd(c);
    end
    while (height[0] > 0) send_cmd(rand_cmd(FN_SCHEDULE, 0));
    send_cmd(rand_cmd(FN_SCHEDULE, 0));
  endtask

  // Exhausts all slots so that a start finds none free, then frees them.
  task automatic test_slot_exhaustion();
    for (int i = 0; i <= RAY_SLOTS; i++) send_cmd(rand_cmd(FN_START, 0));
    for (int i = 0; i < RAY_SLOTS; i++)
      while (busy[i]) send_cmd(rand_cmd(FN_SCHEDULE, i));
  endtask

  // Mostly well-formed traversals with random content, plus noise commands.
  task automatic test_random_traversal(int count);
    ray_cmd_t c;
    int s;
    int sel;
    for (int n = 0; n < count; n++) begin
      s = live_slot();
      sel = $urandom_range(0, 99);
      if (sel < 8) c = rand_cmd(FN_START, 0);
      else if (sel < 18) c = rand_cmd(FN_BEGIN_NODE, s);
      else if (sel < 55) begin
        c = rand_cmd(FN_OFFER, s);
        if ($urandom_range(0, 3) != 0) c.distance = $urandom_range(0, 4000);
      end else if (sel < 85) c = rand_cmd(FN_SCHEDULE, s);
      else if (sel < 93) begin
        c = rand_cmd(FN_HIT_UPDATE, s);
        if ($urandom_range(0, 1) != 0) c.distance = $urandom_range(0, 5000);
      end else c = rand_cmd(FUNC_W'($urandom_range(0, 7)), $urandom_range(0, RAY_SLOTS - 1));
      if (c.func == FN_START && $urandom_range(0, 1) != 0) begin
        c.distance = $urandom_range(0, 100);
        c.far = $urandom_range(3000, 6000);
      end
      send_cmd(c);
    end
  endtask

  task automatic test_register_settings();
    write_reg(CFG_BASE, '1);
    write_reg(CFG_TSTRIDE, ADDR_W'(24'hFF_FFFF));
    write_reg(CFG_NSTRIDE, ADDR_W'(12'hFFF));
    write_reg(CFG_RSTRIDE, ADDR_W'(12'hFFF));
    test_random_traversal(100);
    drain();
    write_reg(CFG_BASE, '0);
    write_reg(CFG_TSTRIDE, ADDR_W'(1));
    write_reg(CFG_NSTRIDE, ADDR_W'(1));
    write_reg(CFG_RSTRIDE, ADDR_W'(1));
    test_random_traversal(75);
    drain();
    write_reg(CFG_BASE, {$urandom(), $urandom()});
    write_reg(CFG_TSTRIDE, ADDR_W'($urandom_range(1, 24'hFF_FFFF)));
    write_reg(CFG_NSTRIDE, ADDR_W'($urandom_range(1, 4095)));
    write_reg(CFG_RSTRIDE, ADDR_W'($urandom_range(1, 4095)));
    test_random_traversal(100);
  endtask

  // The receiver stalls in runs of its own, with stall-free stretches.
  always @(negedge clk) begin
    if ($urandom_range(0, 9) < 3 && $urandom_range(0, 1) == 0) out_ready <= 1'b0;
    else if ($urandom_range(0, 3) != 0) out_ready <= 1'b1;
  end

  // Checks every result transaction against the oldest expectation.
  always @(posedge clk) begin
    ray_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: outcome %0d slot %0d", out_outcome, out_ray_slot_out);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_outcome !== want.outcome) begin
          $error("outcome: expected %0d actual %0d", want.outcome, out_outcome);
          errors++;
        end
        if (out_ray_slot_out !== want.slot) begin
          $error("ray_slot_out: expected %0d actual %0d", want.slot, out_ray_slot_out);
          errors++;
        end
        if (out_fetch_address !== want.addr) begin
          $error("fetch_address: expected %h actual %h", want.addr, out_fetch_address);
          errors++;
        end
        if (out_fetch_length !== want.len) begin
          $error("fetch_length: expected %0d actual %0d", want.len, out_fetch_length);
          errors++;
        end
        if (out_triangle_count !== want.cnt) begin
          $error("triangle_count: expected %0d actual %0d", want.cnt, out_triangle_count);
          errors++;
        end
        if (out_hit_distance !== want.hit_dist) begin
          $error("hit_distance: expected %h actual %h", want.hit_dist, out_hit_distance);
          errors++;
        end
        if (out_hit_primitive !== want.hit_prim) begin
          $error("hit_primitive: expected %h actual %h", want.hit_prim, out_hit_primitive);
          errors++;
        end
      end
    end
  end

  // Watchdog: any cycle without a transaction on either channel counts.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    reset_model();
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_slot_exhaustion();
    drain();
    test_register_settings();
    drain();
    if (errors == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
